/* design/closest_pair_distance_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the closest pair distance block
// Every macro samples on the rising edge of clk and is off during reset.
// ---------------------------------------------------------------------------
`ifndef CLOSEST_PAIR_DISTANCE_ASSERT_SVH
`define CLOSEST_PAIR_DISTANCE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/cpd_pkg.sv */
// ---------------------------------------------------------------------------
// cpd_pkg
// Shared widths, defaults and the controller state type of the closest
// pair distance block.
// ---------------------------------------------------------------------------
package cpd_pkg;

	localparam int MAX_POINTS_DEF = 1024;
	localparam int COORD_BITS_DEF = 16;

	// port field widths
	localparam int FIELD_W = 16;
	localparam int SQ_W    = 36;
	localparam int FIX_W   = 34;
	localparam int FRAC_W  = 16;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_STORE,
		ST_FINISH,
		ST_ROOT
	} cpd_state_t;

endpackage

/* design/cpd_sqrt.sv */
// ---------------------------------------------------------------------------
// cpd_sqrt
// Bit-serial square root: floor(sqrt(d * 2^32)), one root bit per cycle.
// ---------------------------------------------------------------------------
module cpd_sqrt (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [cpd_pkg::SQ_W-1:0] d,
	output logic                     done,
	output logic [cpd_pkg::FIX_W-1:0] root
);

	localparam int RAD_W  = 2 * cpd_pkg::FIX_W;
	localparam int REM_W  = cpd_pkg::FIX_W + 3;
	localparam int STEP_W = $clog2(cpd_pkg::FIX_W + 1);

	logic                      busy_q;
	logic                      done_q;
	logic [STEP_W-1:0]         step_q;
	logic [RAD_W-1:0]          rad_q;
	logic [REM_W-1:0]          rem_q;
	logic [cpd_pkg::FIX_W-1:0] root_q;

	logic [REM_W-1:0] rem_n;
	logic [REM_W-1:0] trial;
	logic             take;

	always_comb begin
		rem_n = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial = REM_W'({root_q, 2'b01});
		take  = rem_n >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(cpd_pkg::FIX_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= {d, (RAD_W - cpd_pkg::SQ_W)'(0)};
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[RAD_W-3:0], 2'b00};
			if (take) begin
				rem_q  <= rem_n - trial;
				root_q <= {root_q[cpd_pkg::FIX_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_n;
				root_q <= {root_q[cpd_pkg::FIX_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* design/closest_pair_distance.sv */
// A point that finds points stored holds busy while it reads the store, passes the reads through
// three pipeline stages, drains and writes; the first point of a set goes straight to the write.
// The last point of a set also holds busy through the square root when two or more are stored.
// A new point is taken only while busy is low; a point past a full store is not stored and, unless
// last, keeps busy low. The result is a one-cycle done strobe; the receiver cannot stall it.
// Reset clears the count and all control, sets best distance to all ones; the store needs no clear.
// ---------------------------------------------------------------------------
// closest_pair_distance
// Stores 2-D points and sweeps the store for every new point it stores, keeping the
// smallest squared distance; gives it with its fixed-point root per set, or no_pair under two points.
// ---------------------------------------------------------------------------
module closest_pair_distance #(
	parameter int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF,
	parameter int COORD_BITS = cpd_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic signed [cpd_pkg::FIELD_W-1:0] point_x,
	input  logic signed [cpd_pkg::FIELD_W-1:0] point_y,
	input  logic                              last_point,
	output logic                              done,
	output logic [cpd_pkg::SQ_W-1:0]          min_dist_squared,
	output logic [cpd_pkg::FIX_W-1:0]         min_dist_fixed,
	output logic                              no_pair
);

	localparam int CW   = COORD_BITS;
	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNTW = $clog2(MAX_POINTS + 1);
	localparam int SQW  = 2 * CW;
	localparam int EW   = (SQW + 1 > cpd_pkg::SQ_W) ? SQW + 1 : cpd_pkg::SQ_W;

	cpd_pkg::cpd_state_t state_q, state_d;

	logic [CNTW-1:0]          count_q;
	logic [CNTW-1:0]          rd_idx_q;
	logic [cpd_pkg::SQ_W-1:0] best_q;
	logic signed [CW-1:0]     px_q, py_q;
	logic                     last_q;

	logic [2*CW-1:0] mem_q [MAX_POINTS];

	logic                 v1_s1, v2_s2, v3_s3;
	logic [2*CW-1:0]      rd_s1;
	logic [CW-1:0]        dx_s2, dy_s2;
	logic [SQW-1:0]       sqx_s3, sqy_s3;

	logic                  done_q;
	logic                  no_pair_q;
	logic [cpd_pkg::SQ_W-1:0]  dist_sq_q;
	logic [cpd_pkg::FIX_W-1:0] dist_fix_q;

	logic signed [CW-1:0] x_c, y_c;
	logic accept, full, issue, drained;
	logic sqrt_start, emit_none, emit_root;
	logic sqrt_done;
	logic [cpd_pkg::FIX_W-1:0] sqrt_root;

	function automatic logic [cpd_pkg::SQ_W-1:0] sat_sq(input logic [SQW-1:0] a,
		input logic [SQW-1:0] b);
		logic [EW-1:0] sum;
		sum = EW'(a) + EW'(b);
		if (sum > EW'({cpd_pkg::SQ_W{1'b1}}))
			return '1;
		return sum[cpd_pkg::SQ_W-1:0];
	endfunction

	// take the coordinate from the low bits of the field, or sign-extend the field when the coordinate is wider
	generate
		if (COORD_BITS <= cpd_pkg::FIELD_W) begin : g_narrow
			assign x_c = point_x[CW-1:0];
			assign y_c = point_y[CW-1:0];
		end else begin : g_wide
			assign x_c = CW'(point_x);
			assign y_c = CW'(point_y);
		end
	endgenerate

	assign accept  = start && (state_q == cpd_pkg::ST_IDLE);
	assign full    = count_q == CNTW'(MAX_POINTS);
	assign issue   = (state_q == cpd_pkg::ST_SWEEP) && (rd_idx_q != count_q);
	assign drained = !issue && !v1_s1 && !v2_s2 && !v3_s3;

	always_comb begin
		state_d    = state_q;
		sqrt_start = 1'b0;
		emit_none  = 1'b0;
		emit_root  = 1'b0;
		unique case (state_q)
			cpd_pkg::ST_IDLE: begin
				if (start) begin
					priority if (full)
						state_d = last_point ? cpd_pkg::ST_FINISH : cpd_pkg::ST_IDLE;
					else if (count_q == '0)
						state_d = cpd_pkg::ST_STORE;
					else
						state_d = cpd_pkg::ST_SWEEP;
				end
			end
			cpd_pkg::ST_SWEEP: begin
				if (drained)
					state_d = cpd_pkg::ST_STORE;
			end
			cpd_pkg::ST_STORE: begin
				state_d = last_q ? cpd_pkg::ST_FINISH : cpd_pkg::ST_IDLE;
			end
			cpd_pkg::ST_FINISH: begin
				if (count_q < CNTW'(2)) begin
					emit_none = 1'b1;
					state_d   = cpd_pkg::ST_IDLE;
				end else begin
					sqrt_start = 1'b1;
					state_d    = cpd_pkg::ST_ROOT;
				end
			end
			cpd_pkg::ST_ROOT: begin
				if (sqrt_done) begin
					emit_root = 1'b1;
					state_d   = cpd_pkg::ST_IDLE;
				end
			end
			default: state_d = cpd_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= cpd_pkg::ST_IDLE;
			count_q  <= '0;
			rd_idx_q <= '0;
			best_q   <= '1;
			v1_s1    <= 1'b0;
			v2_s2    <= 1'b0;
			v3_s3    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			v1_s1   <= issue;
			v2_s2   <= v1_s1;
			v3_s3   <= v2_s2;
			done_q  <= emit_none || emit_root;
			if (accept)
				rd_idx_q <= '0;
			else if (issue)
				rd_idx_q <= rd_idx_q + CNTW'(1);
			if (state_q == cpd_pkg::ST_STORE)
				count_q <= count_q + CNTW'(1);
			else if (emit_none || emit_root)
				count_q <= '0;
			// clear the running minimum on a result, else fold the saturated squared distance into it
			if (emit_none || emit_root)
				best_q <= '1;
			else if (v3_s3) begin
				if (sat_sq(sqx_s3, sqy_s3) < best_q)
					best_q <= sat_sq(sqx_s3, sqy_s3);
			end
		end
	end

	// latch the point on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			px_q   <= x_c;
			py_q   <= y_c;
			last_q <= last_point;
		end
	end

	// point store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (state_q == cpd_pkg::ST_STORE)
			mem_q[count_q[AW-1:0]] <= {py_q, px_q};
		rd_s1 <= mem_q[rd_idx_q[AW-1:0]];
	end

	// distance pipeline: absolute differences, then squares
	always_ff @(posedge clk) begin
		logic signed [CW:0] ddx;
		logic signed [CW:0] ddy;
		ddx = (CW+1)'(px_q) - (CW+1)'(signed'(rd_s1[CW-1:0]));
		ddy = (CW+1)'(py_q) - (CW+1)'(signed'(rd_s1[2*CW-1:CW]));
		dx_s2  <= ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
		dy_s2  <= ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
		sqx_s3 <= SQW'(dx_s2) * SQW'(dx_s2);
		sqy_s3 <= SQW'(dy_s2) * SQW'(dy_s2);
	end

	cpd_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.d      (best_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_ff @(posedge clk) begin
		if (emit_none) begin
			dist_sq_q  <= '0;
			dist_fix_q <= '0;
			no_pair_q  <= 1'b1;
		end else if (emit_root) begin
			dist_sq_q  <= best_q;
			dist_fix_q <= sqrt_root;
			no_pair_q  <= 1'b0;
		end
	end

	assign busy             = state_q != cpd_pkg::ST_IDLE;
	assign done             = done_q;
	assign min_dist_squared = dist_sq_q;
	assign min_dist_fixed   = dist_fix_q;
	assign no_pair          = no_pair_q;

endmodule

/* design/cpd_checker.sv */
// ---------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the closest pair distance block, bound to its top.
// ---------------------------------------------------------------------------
`include "closest_pair_distance_assert.svh"

module cpd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       last_point,
	input logic                       done,
	input logic [cpd_pkg::SQ_W-1:0]   min_dist_squared,
	input logic [cpd_pkg::FIX_W-1:0]  min_dist_fixed,
	input logic                       no_pair
);

	localparam int INT_W = cpd_pkg::FIX_W - cpd_pkg::FRAC_W;

	logic [2*INT_W-1:0] int_sq;

	assign int_sq = (2*INT_W)'(min_dist_fixed[cpd_pkg::FIX_W-1:cpd_pkg::FRAC_W])
		* (2*INT_W)'(min_dist_fixed[cpd_pkg::FIX_W-1:cpd_pkg::FRAC_W]);

	// a point past a full store may pass without busy; the last point of a set never does
	`CPD_ASSERT_NEXT(a_accept_busy, start && !busy && last_point, busy, "last beat did not raise busy")
	`CPD_ASSERT_SAME(a_done_after_busy, done, $past(busy), "result without preceding work")
	`CPD_ASSERT_SAME(a_no_pair_zero, done && no_pair,
		min_dist_squared == '0 && min_dist_fixed == '0, "no-pair result carries distance")
	`CPD_ASSERT_SAME(a_root_floor, done && !no_pair,
		(cpd_pkg::SQ_W)'(int_sq) <= min_dist_squared, "root integer part too large")

endmodule

bind closest_pair_distance cpd_checker u_cpd_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for closest_pair_distance. Point sets are queued up
// front and driven through the start/busy handshake with random sender gaps.
// A behavioral tracker keeps the set and the best squared distance and
// predicts each per-set result, which the monitor compares field by field.
// ---------------------------------------------------------------------------
module tb;

	localparam int MAX_POINTS = cpd_pkg::MAX_POINTS_DEF;
	localparam int RANDOM_POINTS = 560;
	localparam int MIN_RANDOM_SETS = 16;
	localparam longint SQ_ALL_ONES = (64'd1 << cpd_pkg::SQ_W) - 64'd1;

	typedef enum int {
		SPREAD_WIDE,
		SPREAD_CLUSTER,
		SPREAD_EDGE
	} spread_mode_t;

	typedef struct {
		logic signed [cpd_pkg::FIELD_W-1:0] x;
		logic signed [cpd_pkg::FIELD_W-1:0] y;
		logic                               last;
		int unsigned                        idle_pct;
	} point_beat_t;

	typedef struct {
		logic [cpd_pkg::SQ_W-1:0]  squared;
		logic [cpd_pkg::FIX_W-1:0] fixed_root;
		logic                      no_pair;
	} pair_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               start = 1'b0;
	logic                               busy;
	logic signed [cpd_pkg::FIELD_W-1:0] point_x = '0;
	logic signed [cpd_pkg::FIELD_W-1:0] point_y = '0;
	logic                               last_point = 1'b0;
	logic                               done;
	logic [cpd_pkg::SQ_W-1:0]           min_dist_squared;
	logic [cpd_pkg::FIX_W-1:0]          min_dist_fixed;
	logic                               no_pair;

	point_beat_t  pending_points[$];
	pair_result_t expected_results[$];
	point_beat_t  drive_beat;

	// tracked set
	int     set_x[MAX_POINTS];
	int     set_y[MAX_POINTS];
	int     set_count = 0;
	int     set_beats = 0;
	longint best_squared = SQ_ALL_ONES;

	int errors = 0;
	int points_accepted = 0;
	int points_dropped = 0;
	int sets_checked = 0;
	int largest_set = 0;

	closest_pair_distance i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.point_x          (point_x),
		.point_y          (point_y),
		.last_point       (last_point),
		.done             (done),
		.min_dist_squared (min_dist_squared),
		.min_dist_fixed   (min_dist_fixed),
		.no_pair          (no_pair)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// floor(sqrt(d) * 2^16), found bit by bit from the top with exact squares
	function automatic logic [cpd_pkg::FIX_W-1:0] floor_root_16f(
			input logic [cpd_pkg::SQ_W-1:0] d);
		logic [71:0]               radicand;
		logic [71:0]               trial;
		logic [cpd_pkg::FIX_W-1:0] root;
		radicand = {36'd0, d} << 32;
		root = '0;
		for (int b = cpd_pkg::FIX_W - 1; b >= 0; b--) begin
			trial = {38'd0, root | (34'd1 << b)};
			if (trial * trial <= radicand)
				root[b] = 1'b1;
		end
		return root;
	endfunction

	task automatic track_closest_pair(input logic signed [cpd_pkg::FIELD_W-1:0] px,
			input logic signed [cpd_pkg::FIELD_W-1:0] py, input logic last);
		longint       dx;
		longint       dy;
		longint       sq;
		pair_result_t res;
		points_accepted++;
		set_beats++;
		if (set_count < MAX_POINTS) begin
			for (int i = 0; i < set_count; i++) begin
				dx = longint'(px) - longint'(set_x[i]);
				dy = longint'(py) - longint'(set_y[i]);
				sq = dx * dx + dy * dy;
				if (sq > SQ_ALL_ONES)
					sq = SQ_ALL_ONES;
				if (sq < best_squared)
					best_squared = sq;
			end
			set_x[set_count] = int'(px);
			set_y[set_count] = int'(py);
			set_count++;
		end else begin
			points_dropped++;
		end
		if (last) begin
			if (set_count < 2) begin
				res.squared = '0;
				res.fixed_root = '0;
				res.no_pair = 1'b1;
			end else begin
				res.squared = best_squared[cpd_pkg::SQ_W-1:0];
				res.fixed_root = floor_root_16f(best_squared[cpd_pkg::SQ_W-1:0]);
				res.no_pair = 1'b0;
			end
			expected_results.push_back(res);
			if (set_beats > largest_set)
				largest_set = set_beats;
			set_count = 0;
			set_beats = 0;
			best_squared = SQ_ALL_ONES;
		end
	endtask

	// driver: present the next point once the slot is free, maybe after a gap
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			point_x <= '0;
			point_y <= '0;
			last_point <= 1'b0;
		end else begin
			if (start && !busy)
				track_closest_pair(point_x, point_y, last_point);
			if (!start || !busy) begin
				if (pending_points.size() > 0 &&
						$urandom_range(99) >= pending_points[0].idle_pct) begin
					drive_beat = pending_points.pop_front();
					start <= 1'b1;
					point_x <= drive_beat.x;
					point_y <= drive_beat.y;
					last_point <= drive_beat.last;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: one result beat per done strobe, no back-pressure
	always @(posedge clk) begin
		pair_result_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$display("%0t ERROR unexpected result: squared %0d fixed %0d no_pair %0b",
					$time, min_dist_squared, min_dist_fixed, no_pair);
				errors++;
			end else begin
				want = expected_results.pop_front();
				sets_checked++;
				if (min_dist_squared !== want.squared) begin
					$display("%0t ERROR min_dist_squared expected %0d actual %0d",
						$time, want.squared, min_dist_squared);
					errors++;
				end
				if (min_dist_fixed !== want.fixed_root) begin
					$display("%0t ERROR min_dist_fixed expected %0d actual %0d",
						$time, want.fixed_root, min_dist_fixed);
					errors++;
				end
				if (no_pair !== want.no_pair) begin
					$display("%0t ERROR no_pair expected %0b actual %0b",
						$time, want.no_pair, no_pair);
					errors++;
				end
			end
		end
	end

	task automatic queue_point(input logic [cpd_pkg::FIELD_W-1:0] x,
			input logic [cpd_pkg::FIELD_W-1:0] y, input logic last,
			input int unsigned idle_pct);
		point_beat_t b;
		b.x = x;
		b.y = y;
		b.last = last;
		b.idle_pct = idle_pct;
		pending_points.push_back(b);
	endtask

	function automatic logic [cpd_pkg::FIELD_W-1:0] pick_coord(input spread_mode_t mode,
			input logic [cpd_pkg::FIELD_W-1:0] center, input int spread);
		case (mode)
			SPREAD_WIDE: return cpd_pkg::FIELD_W'($urandom);
			SPREAD_CLUSTER: return center + cpd_pkg::FIELD_W'($urandom_range(2 * spread))
				- cpd_pkg::FIELD_W'(spread);
			default: begin
				case ($urandom_range(3))
					0: return 16'h8000;
					1: return 16'h7fff;
					2: return center;
					default: return cpd_pkg::FIELD_W'($urandom);
				endcase
			end
		endcase
	endfunction

	initial begin
		int unsigned  phase_idle[4];
		int           spreads[3];
		int           random_points;
		int           random_sets;
		int           set_size;
		int           pick;
		int           spread;
		spread_mode_t mode;
		logic [cpd_pkg::FIELD_W-1:0] cx;
		logic [cpd_pkg::FIELD_W-1:0] cy;

		phase_idle = '{0, 48, 0, 28};
		spreads = '{2, 64, 4096};

		// directed sets
		queue_point(16'sd0, 16'sd0, 1'b1, 0);                 // lone point
		queue_point(16'h8000, 16'h8000, 1'b0, 0);             // opposite corners
		queue_point(16'h7fff, 16'h7fff, 1'b1, 0);
		queue_point(16'h8000, 16'h7fff, 1'b0, 0);
		queue_point(16'h7fff, 16'h8000, 1'b0, 0);
		queue_point(16'h0000, 16'h0000, 1'b1, 0);
		queue_point(16'sd5, -16'sd7, 1'b0, 0);                // coincident points
		queue_point(16'sd5, -16'sd7, 1'b1, 0);
		queue_point(16'sd100, 16'sd100, 1'b0, 0);             // best pair comes late
		queue_point(16'sd0, 16'sd0, 1'b0, 0);
		queue_point(16'sd3, 16'sd4, 1'b0, 0);
		queue_point(16'sd1000, 16'sd1000, 1'b0, 0);
		queue_point(-16'sd1, -16'sd1, 1'b1, 0);
		queue_point(16'sd12345, -16'sd23456, 1'b0, 0);
		queue_point(16'sd12345, -16'sd23455, 1'b1, 0);
		queue_point(16'hffff, 16'h0000, 1'b0, 0);
		queue_point(16'h0000, 16'hffff, 1'b1, 0);

		// random sets, mostly small
		random_points = 0;
		random_sets = 0;
		while (random_points < RANDOM_POINTS || random_sets < MIN_RANDOM_SETS) begin
			pick = $urandom_range(99);
			if (pick < 5)
				set_size = 1;
			else if (pick < 70)
				set_size = $urandom_range(12, 2);
			else if (pick < 95)
				set_size = $urandom_range(60, 13);
			else
				set_size = $urandom_range(200, 61);
			mode = spread_mode_t'($urandom_range(2));
			spread = spreads[$urandom_range(2)];
			cx = cpd_pkg::FIELD_W'($urandom);
			cy = cpd_pkg::FIELD_W'($urandom);
			for (int i = 0; i < set_size; i++)
				queue_point(pick_coord(mode, cx, spread), pick_coord(mode, cy, spread),
					i == set_size - 1, phase_idle[random_sets % 4]);
			random_points += set_size;
			random_sets++;
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_points.size() > 0 || start || expected_results.size() > 0 || busy)
			@(posedge clk);
		repeat (MAX_POINTS + 64) @(posedge clk);

		$display("Checked %0d point sets from %0d points; largest set %0d points,",
			sets_checked, points_accepted, largest_set);
		$display("%0d points sent past a full store, %0d mismatches.",
			points_dropped, errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Timeout with %0d results outstanding", expected_results.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* closest_pair_distance.f */
+incdir+design
design/cpd_pkg.sv
design/cpd_sqrt.sv
design/closest_pair_distance.sv
design/cpd_checker.sv
verif/tb.sv
